/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define LDS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("lds assertion failed");

// Check an implication whose consequent must hold in the cycle after the antecedent.
`define LDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("lds assertion failed");

`endif

/* hw/rtl/lds_pkg.sv */
package lds_pkg;

	localparam int VALUE_BYTES_DEF   = 32;
	localparam int LENGTH_BITS_DEF   = 16;
	localparam int WINDOW_BYTES      = 32;
	localparam int WINDOW_BITS       = WINDOW_BYTES * 8;
	localparam int WORD_BITS         = 64;
	localparam int WORDS_PER_VALUE   = WINDOW_BITS / WORD_BITS;
	localparam int MAX_SIG_LEN_BYTES = 8;

	localparam logic [7:0] TAG_SEQUENCE = 8'h30;
	localparam logic [7:0] TAG_INTEGER  = 8'h02;

	localparam logic [2:0] LAST_WORD_INDEX = 3'd7;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_MALFORMED = 2'd1,
		STATUS_TOO_LONG  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		PH_SEQ_TAG  = 4'd0,
		PH_SEQ_LEN  = 4'd1,
		PH_SEQ_SKIP = 4'd2,
		PH_R_TAG    = 4'd3,
		PH_R_LEN    = 4'd4,
		PH_R_LENB   = 4'd5,
		PH_R_VAL    = 4'd6,
		PH_S_TAG    = 4'd7,
		PH_S_LEN    = 4'd8,
		PH_S_LENB   = 4'd9,
		PH_S_VAL    = 4'd10,
		PH_DONE     = 4'd11,
		PH_ERR      = 4'd12
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]           word_index;
		logic [WORD_BITS-1:0] data_word;
		logic [1:0]           status;
		logic                 last_word;
	} out_item_t;

	typedef struct packed {
		logic                   load;
		status_t                status;
		logic [WINDOW_BITS-1:0] r_value;
		logic [WINDOW_BITS-1:0] s_value;
	} burst_load_t;

endpackage

/* hw/rtl/lds_parser.sv */
module lds_parser
	import lds_pkg::*;
#(
	parameter int VALUE_BYTES = VALUE_BYTES_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  in_item_t    item,
	output burst_load_t burst
);

	localparam int SVB_W = $clog2(VALUE_BYTES + 1);

	phase_t                 phase_q, phase_d;
	logic [6:0]             len_left_q, len_left_d;
	logic [3:0]             sig_len_q, sig_len_d;
	logic [LENGTH_BITS-1:0] acc_q, acc_d;
	logic [LENGTH_BITS-1:0] cont_q, cont_d;
	logic [SVB_W-1:0]       sig_val_q, sig_val_d;
	logic [WINDOW_BITS-1:0] r_q, r_d, s_q, s_d;
	logic                   too_long_q, too_long_d;

	logic                   is_s;
	phase_t                 len_ph, lenb_ph, val_ph, after_ph;
	logic                   start;
	logic [LENGTH_BITS-1:0] start_len;
	logic [LENGTH_BITS+7:0] acc_wide;
	logic [LENGTH_BITS-1:0] acc_next;
	logic [7:0]             b;
	status_t                status;

	assign b        = item.data_byte;
	assign is_s     = (phase_q == PH_S_TAG) || (phase_q == PH_S_LEN) ||
	                  (phase_q == PH_S_LENB) || (phase_q == PH_S_VAL);
	assign len_ph   = is_s ? PH_S_LEN : PH_R_LEN;
	assign lenb_ph  = is_s ? PH_S_LENB : PH_R_LENB;
	assign val_ph   = is_s ? PH_S_VAL : PH_R_VAL;
	assign after_ph = is_s ? PH_DONE : PH_S_TAG;
	assign acc_wide = {acc_q, b};
	assign acc_next = (|acc_wide[LENGTH_BITS+7:LENGTH_BITS]) ? {LENGTH_BITS{1'b1}}
	                                                        : acc_wide[LENGTH_BITS-1:0];

	always_comb begin
		phase_d    = phase_q;
		len_left_d = len_left_q;
		sig_len_d  = sig_len_q;
		acc_d      = acc_q;
		cont_d     = cont_q;
		sig_val_d  = sig_val_q;
		r_d        = r_q;
		s_d        = s_q;
		too_long_d = too_long_q;
		start      = 1'b0;
		start_len  = '0;
		case (phase_q)
			PH_SEQ_TAG: begin
				phase_d = (b == TAG_SEQUENCE) ? PH_SEQ_LEN : PH_ERR;
			end
			PH_SEQ_LEN: begin
				if (b[7] && (b[6:0] != 7'd0)) begin
					len_left_d = b[6:0];
					phase_d    = PH_SEQ_SKIP;
				end else begin
					phase_d = PH_R_TAG;
				end
			end
			PH_SEQ_SKIP: begin
				len_left_d = len_left_q - 7'd1;
				if (len_left_q == 7'd1) begin
					phase_d = PH_R_TAG;
				end
			end
			PH_R_TAG, PH_S_TAG: begin
				phase_d = (b == TAG_INTEGER) ? len_ph : PH_ERR;
			end
			PH_R_LEN, PH_S_LEN: begin
				if (b[7]) begin
					len_left_d = b[6:0];
					sig_len_d  = 4'd0;
					acc_d      = '0;
					if (b[6:0] == 7'd0) begin
						start = 1'b1;
					end else begin
						phase_d = lenb_ph;
					end
				end else begin
					start     = 1'b1;
					start_len = {{(LENGTH_BITS-7){1'b0}}, b[6:0]};
				end
			end
			PH_R_LENB, PH_S_LENB: begin
				if ((sig_len_q != 4'd0) || (b != 8'd0)) begin
					sig_len_d = sig_len_q + 4'd1;
					acc_d     = acc_next;
				end
				len_left_d = len_left_q - 7'd1;
				if (len_left_q == 7'd1) begin
					start     = 1'b1;
					start_len = acc_d;
				end
				if (((sig_len_q != 4'd0) || (b != 8'd0)) &&
				    (sig_len_q == 4'(MAX_SIG_LEN_BYTES - 1))) begin
					sig_len_d  = sig_len_q + 4'd1;
					acc_d      = acc_q;
					len_left_d = len_left_q;
					start      = 1'b0;
					phase_d    = PH_ERR;
				end
			end
			PH_R_VAL, PH_S_VAL: begin
				if ((sig_val_q != '0) || (b != 8'd0)) begin
					if (sig_val_q < SVB_W'(VALUE_BYTES)) begin
						sig_val_d = sig_val_q + SVB_W'(1);
						if (is_s) begin
							s_d = {s_q[WINDOW_BITS-9:0], b};
						end else begin
							r_d = {r_q[WINDOW_BITS-9:0], b};
						end
					end else begin
						too_long_d = 1'b1;
					end
				end
				cont_d = cont_q - LENGTH_BITS'(1);
				if (cont_q == LENGTH_BITS'(1)) begin
					phase_d = after_ph;
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
		if (start) begin
			cont_d    = start_len;
			sig_val_d = '0;
			phase_d   = (start_len != '0) ? val_ph : after_ph;
		end
	end

	always_comb begin
		if (phase_d != PH_DONE) begin
			status = STATUS_MALFORMED;
		end else if (too_long_d) begin
			status = STATUS_TOO_LONG;
		end else begin
			status = STATUS_OK;
		end
		burst.load    = take && item.last_byte;
		burst.status  = status;
		burst.r_value = (status == STATUS_OK) ? r_d : '0;
		burst.s_value = (status == STATUS_OK) ? s_d : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SEQ_TAG;
			len_left_q <= '0;
			sig_len_q  <= '0;
			acc_q      <= '0;
			cont_q     <= '0;
			sig_val_q  <= '0;
			r_q        <= '0;
			s_q        <= '0;
			too_long_q <= 1'b0;
		end else if (take) begin
			if (item.last_byte) begin
				phase_q    <= PH_SEQ_TAG;
				len_left_q <= '0;
				sig_len_q  <= '0;
				acc_q      <= '0;
				cont_q     <= '0;
				sig_val_q  <= '0;
				r_q        <= '0;
				s_q        <= '0;
				too_long_q <= 1'b0;
			end else begin
				phase_q    <= phase_d;
				len_left_q <= len_left_d;
				sig_len_q  <= sig_len_d;
				acc_q      <= acc_d;
				cont_q     <= cont_d;
				sig_val_q  <= sig_val_d;
				r_q        <= r_d;
				s_q        <= s_d;
				too_long_q <= too_long_d;
			end
		end
	end

endmodule

/* hw/rtl/lds_emitter.sv */
module lds_emitter
	import lds_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  burst_load_t burst,
	output logic        free,
	output logic        word_valid,
	input  logic        word_ready,
	output out_item_t   word_item
);

	logic                   busy_q;
	logic [2:0]             idx_q;
	status_t                status_q;
	logic [WINDOW_BITS-1:0] r_q, s_q;
	logic [WINDOW_BITS-1:0] sel;
	logic [1:0]             slot;
	logic                   pop;

	assign pop        = busy_q && word_ready;
	assign free       = !busy_q || (pop && (idx_q == LAST_WORD_INDEX));
	assign word_valid = busy_q;
	assign sel        = idx_q[2] ? s_q : r_q;
	assign slot       = 2'(WORDS_PER_VALUE - 1) - idx_q[1:0];

	always_comb begin
		word_item.word_index = idx_q;
		word_item.data_word  = sel[slot * WORD_BITS +: WORD_BITS];
		word_item.status     = status_q;
		word_item.last_word  = (idx_q == LAST_WORD_INDEX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (burst.load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (pop) begin
			if (idx_q == LAST_WORD_INDEX) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (burst.load) begin
			status_q <= burst.status;
			r_q      <= burst.r_value;
			s_q      <= burst.s_value;
		end
	end

endmodule

/* hw/rtl/lax_der_signature_parser.sv */
// DER signature parser: one signature byte per transaction on the sig_*
// channel, last_byte set on the final byte of each signature.
// Each byte is parsed in the cycle it is accepted; the parse state is the only
// input-side storage: one byte per cycle is sustained while sig_ready is high.
// The last byte loads an eight-word result buffer; the words leave on the
// word_* channel, R then S, most significant first, starting the cycle after
// the last byte is accepted, one word per cycle while word_ready is high.
// Malformed and too-long signatures return eight zero words with their status.
// Bytes of the next signature are accepted while the burst drains. A last
// byte is held off (sig_ready low) only while the buffer still has words
// other than the final one being taken this cycle, so a new burst can load
// in the same cycle the final word of the previous burst is taken.
// A stalled receiver holds the current word unchanged.
// Reset (arst_n low) clears the parse state and drops any pending words;
// the block is ready on the first cycle after reset.
module lax_der_signature_parser
	import lds_pkg::*;
#(
	parameter int VALUE_BYTES = VALUE_BYTES_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      sig_valid,
	output logic      sig_ready,
	input  in_item_t  sig_item,
	output logic      word_valid,
	input  logic      word_ready,
	output out_item_t word_item
);

	burst_load_t burst;
	logic        free;
	logic        take;

	assign sig_ready = free || !sig_item.last_byte;
	assign take      = sig_valid && sig_ready;

	lds_parser #(
		.VALUE_BYTES(VALUE_BYTES),
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (take),
		.item  (sig_item),
		.burst (burst)
	);

	lds_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.burst     (burst),
		.free      (free),
		.word_valid(word_valid),
		.word_ready(word_ready),
		.word_item (word_item)
	);

endmodule

/* hw/rtl/lds_checker.sv */
`include "assert_macros.svh"

module lds_checker
	import lds_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      sig_valid,
	input logic      sig_ready,
	input in_item_t  sig_item,
	input logic      word_valid,
	input logic      word_ready,
	input out_item_t word_item
);

	`LDS_ASSERT_NEXT(a_word_hold, clk, arst_n, word_valid && !word_ready,
		word_valid && $stable(word_item))
	`LDS_ASSERT_NEXT(a_burst_continues, clk, arst_n,
		word_valid && word_ready && !word_item.last_word,
		word_valid && (word_item.word_index == 3'($past(word_item.word_index) + 3'd1)))
	`LDS_ASSERT(a_last_at_end, clk, arst_n,
		!word_valid || (word_item.last_word == (word_item.word_index == LAST_WORD_INDEX)))
	`LDS_ASSERT(a_reject_zero, clk, arst_n,
		!word_valid || (word_item.status == STATUS_OK) || (word_item.data_word == '0))
	`LDS_ASSERT_NEXT(a_burst_starts, clk, arst_n,
		sig_valid && sig_ready && sig_item.last_byte,
		word_valid && (word_item.word_index == 3'd0))

endmodule

bind lax_der_signature_parser lds_checker u_lds_checker (.*);

/* bench/signature_check_pkg.sv */
package signature_check_pkg;
	import lds_pkg::*;

	localparam logic [LENGTH_BITS_DEF-1:0] LENGTH_MAX = '1;

	class word_scoreboard;
		phase_t                     phase;
		logic [6:0]                 length_left;
		logic [3:0]                 length_digits;
		logic [LENGTH_BITS_DEF-1:0] length_acc;
		logic [LENGTH_BITS_DEF-1:0] content_left;
		logic [5:0]                 value_count;
		logic [WORD_BITS-1:0]       value_words [2*WORDS_PER_VALUE];
		logic                       too_long;
		out_item_t                  expected_words [$];
		int                         errors;

		function new();
			errors = 0;
			clear_parse();
		endfunction

		function void clear_parse();
			phase = PH_SEQ_TAG;
			length_left = '0;
			length_digits = '0;
			length_acc = '0;
			content_left = '0;
			value_count = '0;
			foreach (value_words[i]) value_words[i] = '0;
			too_long = 1'b0;
		endfunction

		function void begin_content(logic [LENGTH_BITS_DEF-1:0] len, logic in_s);
			content_left = len;
			value_count = '0;
			if (len != 0) phase = in_s ? PH_S_VAL : PH_R_VAL;
			else phase = in_s ? PH_DONE : PH_S_TAG;
		endfunction

		function void parse_byte(logic [7:0] b);
			logic                       in_s;
			logic [LENGTH_BITS_DEF+7:0] grown;
			logic [WINDOW_BITS-1:0]     window;
			int                         first;
			in_s = (phase >= PH_S_TAG);
			first = in_s ? WORDS_PER_VALUE : 0;
			case (phase)
				PH_SEQ_TAG: phase = (b == TAG_SEQUENCE) ? PH_SEQ_LEN : PH_ERR;
				PH_SEQ_LEN: begin
					if (b[7] && b[6:0] != 7'd0) begin
						length_left = b[6:0];
						phase = PH_SEQ_SKIP;
					end else begin
						phase = PH_R_TAG;
					end
				end
				PH_SEQ_SKIP: begin
					length_left = length_left - 7'd1;
					if (length_left == 7'd0) phase = PH_R_TAG;
				end
				PH_R_TAG, PH_S_TAG: begin
					if (b != TAG_INTEGER) phase = PH_ERR;
					else phase = in_s ? PH_S_LEN : PH_R_LEN;
				end
				PH_R_LEN, PH_S_LEN: begin
					if (b[7]) begin
						length_left = b[6:0];
						length_digits = '0;
						length_acc = '0;
						if (b[6:0] == 7'd0) begin_content('0, in_s);
						else phase = in_s ? PH_S_LENB : PH_R_LENB;
					end else begin
						begin_content(LENGTH_BITS_DEF'(b), in_s);
					end
				end
				PH_R_LENB, PH_S_LENB: begin
					if (length_digits != 4'd0 || b != 8'd0) begin
						length_digits = length_digits + 4'd1;
						grown = {length_acc, b};
						if (grown[LENGTH_BITS_DEF+7:LENGTH_BITS_DEF] != 8'd0) length_acc = LENGTH_MAX;
						else length_acc = grown[LENGTH_BITS_DEF-1:0];
					end
					if (length_digits >= MAX_SIG_LEN_BYTES) begin
						phase = PH_ERR;
					end else begin
						length_left = length_left - 7'd1;
						if (length_left == 7'd0) begin_content(length_acc, in_s);
					end
				end
				PH_R_VAL, PH_S_VAL: begin
					if (value_count != 6'd0 || b != 8'd0) begin
						if (value_count < VALUE_BYTES_DEF) begin
							value_count = value_count + 6'd1;
							window = '0;
							for (int i = 0; i < WORDS_PER_VALUE; i++)
								window = {window[WINDOW_BITS-WORD_BITS-1:0], value_words[first+i]};
							window = {window[WINDOW_BITS-9:0], b};
							for (int i = 0; i < WORDS_PER_VALUE; i++)
								value_words[first+i] = window[WINDOW_BITS-1-i*WORD_BITS -: WORD_BITS];
						end else begin
							too_long = 1'b1;
						end
					end
					content_left = content_left - 1'b1;
					if (content_left == 0) phase = in_s ? PH_DONE : PH_S_TAG;
				end
				default: ;
			endcase
		endfunction

		function void note_byte(in_item_t item);
			out_item_t word;
			status_t   verdict;
			parse_byte(item.data_byte);
			if (item.last_byte) begin
				if (phase != PH_DONE) verdict = STATUS_MALFORMED;
				else if (too_long) verdict = STATUS_TOO_LONG;
				else verdict = STATUS_OK;
				for (int k = 0; k < 2*WORDS_PER_VALUE; k++) begin
					word.word_index = 3'(k);
					word.data_word = (verdict == STATUS_OK) ? value_words[k] : '0;
					word.status = verdict;
					word.last_word = (3'(k) == LAST_WORD_INDEX);
					expected_words.push_back(word);
				end
				clear_parse();
			end
		endfunction

		task report(string msg);
			$display("MISMATCH %s", msg);
			errors++;
		endtask

		task check_word(out_item_t got);
			out_item_t want;
			if (expected_words.size() == 0) begin
				report($sformatf("word %0d arrived with nothing expected", got.word_index));
			end else begin
				want = expected_words.pop_front();
				if (got.word_index !== want.word_index || got.data_word !== want.data_word ||
						got.status !== want.status || got.last_word !== want.last_word)
					report($sformatf("got idx %0d data %h st %0d last %0b, want idx %0d data %h st %0d last %0b",
						got.word_index, got.data_word, got.status, got.last_word,
						want.word_index, want.data_word, want.status, want.last_word));
			end
		endtask

		function int pending();
			return expected_words.size();
		endfunction
	endclass

endpackage

/* bench/lax_der_signature_parser_test.sv */
module lax_der_signature_parser_test;
	import lds_pkg::*;
	import signature_check_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int PHASE_BYTES    = 12;

	logic      clk;
	logic      arst_n;
	logic      sig_valid;
	logic      sig_ready;
	in_item_t  sig_item;
	logic      word_valid;
	logic      word_ready;
	out_item_t word_item;

	word_scoreboard sb = new();
	logic [7:0]     sig_bytes [$];
	int             send_idle_pct;
	int             recv_stall_pct;
	int             sent_bytes;
	int             idle_cycles;
	int             send_pcts [4] = '{0, 61, 0, 35};
	int             recv_pcts [4] = '{0, 0, 61, 35};

	lax_der_signature_parser u_top (
		.clk,
		.arst_n,
		.sig_valid,
		.sig_ready,
		.sig_item,
		.word_valid,
		.word_ready,
		.word_item
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_value_length();
		int roll;
		roll = $urandom_range(15);
		if (roll == 0) return 0;
		if (roll <= 10) return $urandom_range(6, 1);
		if (roll <= 12) return $urandom_range(31, 7);
		if (roll == 13) return VALUE_BYTES_DEF;
		return $urandom_range(VALUE_BYTES_DEF + 4, VALUE_BYTES_DEF + 1);
	endfunction

	task automatic push_integer(input int sig_len, input int lead);
		int total;
		int pad;
		int digits;
		total = sig_len + lead;
		sig_bytes.push_back(TAG_INTEGER);
		if (total < 128 && $urandom_range(3) != 0) begin
			sig_bytes.push_back(8'(total));
		end else begin
			pad = ($urandom_range(2) == 0) ? $urandom_range(2, 1) : 0;
			digits = (total > 255) ? 2 : (total > 0) ? 1 : 0;
			sig_bytes.push_back(8'(8'h80 + pad + digits));
			repeat (pad) sig_bytes.push_back(8'h00);
			if (digits == 2) sig_bytes.push_back(8'(total >> 8));
			if (digits > 0) sig_bytes.push_back(8'(total));
		end
		repeat (lead) sig_bytes.push_back(8'h00);
		for (int i = 0; i < sig_len; i++)
			sig_bytes.push_back((i == 0) ? 8'($urandom_range(255, 1)) : 8'($urandom));
	endtask

	task automatic send_signature();
		in_item_t item;
		foreach (sig_bytes[i]) begin
			item.data_byte = sig_bytes[i];
			item.last_byte = (i == sig_bytes.size() - 1);
			while ($urandom_range(99) < send_idle_pct) begin
				sig_valid <= 1'b0;
				@(posedge clk);
			end
			sig_valid <= 1'b1;
			sig_item <= item;
			do @(posedge clk); while (!sig_ready);
			sb.note_byte(item);
			sent_bytes++;
		end
	endtask

	initial begin
		word_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && word_valid && word_ready) sb.check_word(word_item);
			word_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (sig_valid && sig_ready) || (word_valid && word_ready)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int kind;
		int skip;
		int cut;
		int idx;
		int start_bytes;
		arst_n = 1'b0;
		sig_valid = 1'b0;
		sig_item = '0;
		sent_bytes = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sig_bytes = '{8'h30, 8'h06, 8'h02, 8'h01, 8'h80, 8'h02, 8'h01, 8'h7f};
		send_signature();
		sig_bytes = '{8'h30, 8'h80, 8'h02, 8'h00, 8'h02, 8'h80};
		send_signature();
		sig_bytes = '{8'h30, 8'h45, 8'h02, 8'h20};
		repeat (32) sig_bytes.push_back(8'hff);
		sig_bytes.push_back(8'h02);
		sig_bytes.push_back(8'h21);
		sig_bytes.push_back(8'h00);
		repeat (32) sig_bytes.push_back(8'hff);
		send_signature();
		sig_bytes = '{8'h30, 8'h82, 8'h00, 8'h10, 8'h02, 8'h83, 8'h00, 8'h00, 8'h02, 8'haa,
			8'h55, 8'h02, 8'h84, 8'h00, 8'h00, 8'h00, 8'h01, 8'h80};
		send_signature();
		sig_bytes = '{8'h31, 8'h06, 8'h02, 8'h01, 8'h01, 8'h02, 8'h01, 8'h01};
		send_signature();
		sig_bytes = '{8'h30, 8'h06, 8'h03, 8'h01, 8'h01, 8'h02, 8'h01, 8'h01};
		send_signature();
		sig_bytes = '{8'h30, 8'h06, 8'h02, 8'h01, 8'h01, 8'h04, 8'h01, 8'h01};
		send_signature();
		sig_bytes = '{8'h30, 8'h00, 8'h02, 8'h88, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
			8'h01, 8'h01, 8'h00};
		send_signature();
		sig_bytes = '{8'h30, 8'h00, 8'h02, 8'h87, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
			8'hff, 8'h01};
		send_signature();
		sig_bytes = '{8'h30, 8'h00, 8'h02, 8'h01, 8'h05, 8'h02, 8'h83, 8'h01, 8'h00, 8'h00};
		send_signature();
		sig_bytes = '{8'h30};
		send_signature();
		sig_bytes = '{8'h30, 8'h82, 8'h01};
		send_signature();
		sig_bytes = '{8'h30, 8'h00, 8'h02, 8'h05, 8'h01, 8'h02};
		send_signature();
		sig_bytes = '{8'h30, 8'h00, 8'h02, 8'h01, 8'h01, 8'h02};
		send_signature();
		sig_bytes = '{8'h30, 8'h00, 8'h02, 8'h01, 8'h01, 8'h02, 8'h02, 8'h01};
		send_signature();
		sig_bytes = '{8'h30, 8'h06, 8'h02, 8'h01, 8'h01, 8'h02, 8'h01, 8'h01, 8'hff, 8'h00, 8'h30};
		send_signature();
		sig_bytes = '{8'h30, 8'h83, 8'hff, 8'hff, 8'hff, 8'h02, 8'h01, 8'h01, 8'h02, 8'h01, 8'h01};
		send_signature();
		sig_bytes = '{8'h00};
		send_signature();
		sig_bytes = '{8'hff};
		send_signature();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = send_pcts[p];
			recv_stall_pct = recv_pcts[p];
			start_bytes = sent_bytes;
			while (sent_bytes - start_bytes < PHASE_BYTES) begin
				kind = $urandom_range(99);
				if (kind < 8) begin
					sig_bytes.delete();
					repeat ($urandom_range(6, 1)) sig_bytes.push_back(8'($urandom));
				end else begin
					sig_bytes = '{TAG_SEQUENCE};
					if ($urandom_range(3) != 0) begin
						sig_bytes.push_back(8'($urandom_range(127)));
					end else begin
						skip = $urandom_range(3);
						sig_bytes.push_back(8'(8'h80 + skip));
						repeat (skip) sig_bytes.push_back(8'($urandom));
					end
					push_integer(pick_value_length(),
						($urandom_range(7) == 0) ? $urandom_range(3, 1) : 0);
					push_integer(pick_value_length(),
						($urandom_range(7) == 0) ? $urandom_range(3, 1) : 0);
					if ($urandom_range(7) == 0)
						repeat ($urandom_range(2, 1)) sig_bytes.push_back(8'($urandom));
					if (kind < 22) begin
						cut = $urandom_range(sig_bytes.size() - 1, 1);
						while (sig_bytes.size() > cut) void'(sig_bytes.pop_back());
					end else if (kind < 30) begin
						idx = $urandom_range(sig_bytes.size() - 1);
						sig_bytes[idx] = 8'($urandom);
					end
				end
				send_signature();
			end
		end
		sig_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/lds_pkg.sv
hw/rtl/lds_parser.sv
hw/rtl/lds_emitter.sv
hw/rtl/lax_der_signature_parser.sv
hw/rtl/lds_checker.sv
bench/signature_check_pkg.sv
bench/lax_der_signature_parser_test.sv
